### design/ihds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ihds_pkg;

    typedef enum logic [1:0] {
        FMT_UNKNOWN = 2'd0,
        FMT_PNG     = 2'd1,
        FMT_BMP     = 2'd2,
        FMT_JPEG    = 2'd3
    } fmt_t;

    typedef enum logic [2:0] {
        PH_SEEK   = 3'd0,
        PH_RUN    = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_BODY   = 3'd4,
        PH_DONE   = 3'd5,
        PH_FAIL   = 3'd6
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        fmt_t        image_format;
        logic        dims_valid;
        logic [31:0] image_width;
        logic [31:0] image_height;
    } dims_result_t;

    // Marker bytes
    localparam logic [7:0] PNG_FIRST   = 8'd137;
    localparam logic [7:0] BMP_FIRST   = 8'h42;
    localparam logic [7:0] BMP_SECOND  = 8'h4D;
    localparam logic [7:0] JPEG_PREFIX = 8'hFF;
    localparam logic [7:0] JPEG_SOI    = 8'hD8;
    localparam logic [7:0] JPEG_EOI    = 8'hD9;

    // Header offsets
    localparam logic [4:0] OFF_MAX       = 5'd31;
    localparam logic [4:0] OFF_PNG_SIG   = 5'd8;
    localparam logic [4:0] OFF_IHDR      = 5'd12;
    localparam logic [4:0] OFF_PNG_W     = 5'd16;
    localparam logic [4:0] OFF_PNG_H     = 5'd20;
    localparam logic [4:0] OFF_PNG_END   = 5'd24;
    localparam logic [4:0] OFF_BMP_W     = 5'd18;
    localparam logic [4:0] OFF_BMP_H     = 5'd22;
    localparam logic [4:0] OFF_BMP_END   = 5'd26;
    localparam logic [4:0] MIN_LAST_PNG  = 5'd23;
    localparam logic [4:0] MIN_LAST_BMP  = 5'd25;
    localparam logic [4:0] MIN_LAST_JPEG = 5'd3;

    localparam logic [15:0] SEG_LEN_MIN = 16'd2;
    localparam logic [15:0] SOF_LEN_MIN = 16'd7;
    localparam logic [2:0]  PAYLOAD_MAX = 3'd7;

    function automatic logic [7:0] png_sig(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'd137;
            3'd1:    v = 8'd80;
            3'd2:    v = 8'd78;
            3'd3:    v = 8'd71;
            3'd4:    v = 8'd13;
            3'd5:    v = 8'd10;
            3'd6:    v = 8'd26;
            3'd7:    v = 8'd10;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] ihdr_tag(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h49;
            2'd1:    v = 8'h48;
            2'd2:    v = 8'h44;
            2'd3:    v = 8'h52;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic is_sof(input logic [7:0] m);
        return (m >= 8'hC0 && m <= 8'hC3) || (m >= 8'hC5 && m <= 8'hC7) ||
               (m >= 8'hC9 && m <= 8'hCB) || (m >= 8'hCD && m <= 8'hCF);
    endfunction

    // Place a byte at a little-endian lane of a 32-bit word
    function automatic logic [31:0] place_byte(input logic [7:0] b, input logic [1:0] lane);
        logic [31:0] v;
        case (lane)
            2'd0:    v = {24'd0, b};
            2'd1:    v = {16'd0, b, 8'd0};
            2'd2:    v = {8'd0, b, 16'd0};
            2'd3:    v = {b, 24'd0};
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### design/ihds_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ihds_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ihds_dims_if;
    logic        valid;
    logic        ready;
    logic [1:0]  image_format;
    logic        dims_valid;
    logic [31:0] image_width;
    logic [31:0] image_height;

    modport source (output valid, output image_format, output dims_valid,
                    output image_width, output image_height, input ready);
    modport sink   (input valid, input image_format, input dims_valid,
                    input image_width, input image_height, output ready);
endinterface

`default_nettype wire

### design/ihds_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module ihds_in_reg
    import ihds_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    ihds_byte_if.sink       byte_chan,
    input  wire logic       advance,
    output logic            item_valid,
    output byte_item_t      item
);

    logic       valid_reg;
    byte_item_t item_reg;

    // Take a new byte whenever the held one is empty or leaves this cycle
    assign byte_chan.ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (byte_chan.ready)
        begin
            valid_reg <= byte_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_chan.valid && byte_chan.ready)
        begin
            item_reg <= '{data_byte: byte_chan.data_byte, last_byte: byte_chan.last_byte};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

### design/ihds_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module ihds_parser
    import ihds_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   item_valid,
    input  wire byte_item_t item,
    input  wire logic   out_free,
    output logic        advance,
    output logic        load,
    output dims_result_t result
);

    logic [4:0]  header_offset_reg,  header_offset_next;
    fmt_t        format_kind_reg,    format_kind_next;
    logic        header_failed_reg,  header_failed_next;
    logic [31:0] width_capture_reg,  width_capture_next;
    logic [31:0] height_capture_reg, height_capture_next;
    phase_t      jpeg_phase_reg,     jpeg_phase_next;
    logic        marker_is_frame_reg, marker_is_frame_next;
    logic [15:0] segment_left_reg,   segment_left_next;
    logic [2:0]  payload_index_reg,  payload_index_next;
    logic        frame_found_reg,    frame_found_next;

    logic [4:0]  off;
    logic [7:0]  b;
    logic [1:0]  lane;
    logic [15:0] seg_len;
    logic [15:0] seg_dec;
    logic [31:0] h_abs;
    logic        hdr_ok;

    // A last byte waits until the result register can take its result
    assign advance = item_valid && (!item.last_byte || out_free);
    assign load    = advance && item.last_byte;

    assign off     = header_offset_reg;
    assign b       = item.data_byte;
    assign lane    = 2'(off[1:0] - 2'd2);
    assign seg_len = {segment_left_reg[15:8], b};
    assign seg_dec = segment_left_reg - 16'd1;

    always_comb
    begin
        header_offset_next   = header_offset_reg;
        format_kind_next     = format_kind_reg;
        header_failed_next   = header_failed_reg;
        width_capture_next   = width_capture_reg;
        height_capture_next  = height_capture_reg;
        jpeg_phase_next      = jpeg_phase_reg;
        marker_is_frame_next = marker_is_frame_reg;
        segment_left_next    = segment_left_reg;
        payload_index_next   = payload_index_reg;
        frame_found_next     = frame_found_reg;
        result               = '0;
        h_abs                = '0;
        hdr_ok               = 1'b0;

        if (advance)
        begin
            if (!header_failed_reg)
            begin
                if (off == 5'd0)
                begin
                    case (b)
                        PNG_FIRST:   format_kind_next = FMT_PNG;
                        BMP_FIRST:   format_kind_next = FMT_BMP;
                        JPEG_PREFIX: format_kind_next = FMT_JPEG;
                        default:     header_failed_next = 1'b1;
                    endcase
                end
                else
                begin
                    case (format_kind_reg)
                        FMT_PNG:
                        begin
                            if (off < OFF_PNG_SIG)
                            begin
                                if (b != png_sig(off[2:0]))
                                begin
                                    header_failed_next = 1'b1;
                                end
                            end
                            else if (off >= OFF_IHDR && off < OFF_PNG_W)
                            begin
                                if (b != ihdr_tag(off[1:0]))
                                begin
                                    header_failed_next = 1'b1;
                                end
                            end
                            else if (off >= OFF_PNG_W && off < OFF_PNG_H)
                            begin
                                width_capture_next = {width_capture_reg[23:0], b};
                            end
                            else if (off >= OFF_PNG_H && off < OFF_PNG_END)
                            begin
                                height_capture_next = {height_capture_reg[23:0], b};
                            end
                        end
                        FMT_BMP:
                        begin
                            if (off == 5'd1)
                            begin
                                if (b != BMP_SECOND)
                                begin
                                    header_failed_next = 1'b1;
                                end
                            end
                            else if (off >= OFF_BMP_W && off < OFF_BMP_H)
                            begin
                                width_capture_next = width_capture_reg | place_byte(b, lane);
                            end
                            else if (off >= OFF_BMP_H && off < OFF_BMP_END)
                            begin
                                height_capture_next = height_capture_reg | place_byte(b, lane);
                            end
                        end
                        FMT_JPEG:
                        begin
                            if (off == 5'd1)
                            begin
                                if (b != JPEG_SOI)
                                begin
                                    header_failed_next = 1'b1;
                                end
                            end
                            else
                            begin
                                case (jpeg_phase_reg)
                                    PH_SEEK:
                                    begin
                                        if (b == JPEG_PREFIX)
                                        begin
                                            jpeg_phase_next = PH_RUN;
                                        end
                                    end
                                    PH_RUN:
                                    begin
                                        if (b == JPEG_SOI || b == JPEG_EOI)
                                        begin
                                            jpeg_phase_next = PH_SEEK;
                                        end
                                        else if (b != JPEG_PREFIX)
                                        begin
                                            marker_is_frame_next = is_sof(b);
                                            jpeg_phase_next      = PH_LEN_HI;
                                        end
                                    end
                                    PH_LEN_HI:
                                    begin
                                        segment_left_next = {b, 8'd0};
                                        jpeg_phase_next   = PH_LEN_LO;
                                    end
                                    PH_LEN_LO:
                                    begin
                                        if (seg_len < SEG_LEN_MIN ||
                                            (marker_is_frame_reg && seg_len < SOF_LEN_MIN))
                                        begin
                                            segment_left_next = seg_len;
                                            jpeg_phase_next   = PH_FAIL;
                                        end
                                        else
                                        begin
                                            segment_left_next  = seg_len - SEG_LEN_MIN;
                                            payload_index_next = 3'd0;
                                            jpeg_phase_next    = (seg_len == SEG_LEN_MIN) ?
                                                                 PH_SEEK : PH_BODY;
                                        end
                                    end
                                    PH_BODY:
                                    begin
                                        if (marker_is_frame_reg)
                                        begin
                                            if (payload_index_reg == 3'd1 ||
                                                payload_index_reg == 3'd2)
                                            begin
                                                height_capture_next =
                                                    {height_capture_reg[23:0], b};
                                            end
                                            else if (payload_index_reg == 3'd3 ||
                                                     payload_index_reg == 3'd4)
                                            begin
                                                width_capture_next =
                                                    {width_capture_reg[23:0], b};
                                            end
                                            if (payload_index_reg < PAYLOAD_MAX)
                                            begin
                                                payload_index_next = payload_index_reg + 3'd1;
                                            end
                                        end
                                        segment_left_next = seg_dec;
                                        if (seg_dec == 16'd0)
                                        begin
                                            if (marker_is_frame_reg)
                                            begin
                                                frame_found_next = 1'b1;
                                                jpeg_phase_next  = PH_DONE;
                                            end
                                            else
                                            begin
                                                jpeg_phase_next = PH_SEEK;
                                            end
                                        end
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            if (off != OFF_MAX)
            begin
                header_offset_next = off + 5'd1;
            end

            if (item.last_byte)
            begin
                // Build the result from the updated captures, then clear for the next file
                h_abs = height_capture_next;
                if (!header_failed_next)
                begin
                    if (format_kind_next == FMT_PNG && off >= MIN_LAST_PNG)
                    begin
                        result.image_format = FMT_PNG;
                        hdr_ok              = 1'b1;
                    end
                    else if (format_kind_next == FMT_BMP && off >= MIN_LAST_BMP)
                    begin
                        result.image_format = FMT_BMP;
                        hdr_ok              = 1'b1;
                        if (height_capture_next[31])
                        begin
                            h_abs = 32'd0 - height_capture_next;
                        end
                    end
                    else if (format_kind_next == FMT_JPEG && off >= MIN_LAST_JPEG)
                    begin
                        result.image_format = FMT_JPEG;
                        hdr_ok              = frame_found_next;
                    end
                end
                result.dims_valid = hdr_ok && (width_capture_next != 32'd0) &&
                                    (h_abs != 32'd0);
                result.image_width  = result.dims_valid ? width_capture_next : 32'd0;
                result.image_height = result.dims_valid ? h_abs : 32'd0;

                header_offset_next   = '0;
                format_kind_next     = FMT_UNKNOWN;
                header_failed_next   = 1'b0;
                width_capture_next   = '0;
                height_capture_next  = '0;
                jpeg_phase_next      = PH_SEEK;
                marker_is_frame_next = 1'b0;
                segment_left_next    = '0;
                payload_index_next   = '0;
                frame_found_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_offset_reg   <= '0;
            format_kind_reg     <= FMT_UNKNOWN;
            header_failed_reg   <= 1'b0;
            width_capture_reg   <= '0;
            height_capture_reg  <= '0;
            jpeg_phase_reg      <= PH_SEEK;
            marker_is_frame_reg <= 1'b0;
            segment_left_reg    <= '0;
            payload_index_reg   <= '0;
            frame_found_reg     <= 1'b0;
        end
        else
        begin
            header_offset_reg   <= header_offset_next;
            format_kind_reg     <= format_kind_next;
            header_failed_reg   <= header_failed_next;
            width_capture_reg   <= width_capture_next;
            height_capture_reg  <= height_capture_next;
            jpeg_phase_reg      <= jpeg_phase_next;
            marker_is_frame_reg <= marker_is_frame_next;
            segment_left_reg    <= segment_left_next;
            payload_index_reg   <= payload_index_next;
            frame_found_reg     <= frame_found_next;
        end
    end

endmodule

`default_nettype wire

### design/ihds_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module ihds_out_reg
    import ihds_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   load,
    input  wire dims_result_t result,
    output logic        out_free,
    ihds_dims_if.source dims_chan
);

    logic         valid_reg;
    dims_result_t result_reg;

    // Free when empty or when the held transaction leaves this cycle
    assign out_free = !valid_reg || dims_chan.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (dims_chan.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign dims_chan.valid        = valid_reg;
    assign dims_chan.image_format = result_reg.image_format;
    assign dims_chan.dims_valid   = result_reg.dims_valid;
    assign dims_chan.image_width  = result_reg.image_width;
    assign dims_chan.image_height = result_reg.image_height;

endmodule

`default_nettype wire

### design/image_header_dimension_sniffer.sv
// Image header dimension sniffer: tells PNG, BMP and JPEG files apart and reports
// their pixel width and height.
//
// byte_chan carries the file one byte per transaction, in file order; last_byte
// marks the final byte. dims_chan carries one transaction per file: the format
// code (0 unknown, 1 png, 2 bmp, 3 jpeg), dims_valid, and width and height
// (zero unless dims_valid). No transaction is produced for other bytes.
//
// Throughput: one byte per cycle, sustained across file boundaries, while the
// result register can take each result. Each byte passes one input register
// and then the combinational header/marker-walk logic; the result register is
// loaded from that logic. The last byte waits in the input register until the
// result register is free; the result then shows on dims_chan from there.
//
// Reset (rst_n low, asynchronous) empties both registers and puts the parser at
// the start of a file. The parser also returns to that state by itself after
// each last byte. When the receiver stalls, the result register holds its
// transaction; bytes of the next file keep flowing until its own last byte,
// which then waits in the input register and backpressures byte_chan.
`timescale 1ns / 1ps
`default_nettype none

module image_header_dimension_sniffer
    import ihds_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ihds_byte_if.sink   byte_chan,
    ihds_dims_if.source dims_chan
);

    logic         item_valid;
    byte_item_t   item;
    logic         advance;
    logic         load;
    logic         out_free;
    dims_result_t result;

    // Input register: hold one byte in front of the parser
    ihds_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_chan  (byte_chan),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Parser: advance the header/marker state, build the result on the last byte
    ihds_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .advance    (advance),
        .load       (load),
        .result     (result)
    );

    // Result register: hold the transaction until the receiver takes it
    ihds_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .result    (result),
        .out_free  (out_free),
        .dims_chan (dims_chan)
    );

endmodule

`default_nettype wire

### design/ihds_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ihds_checker
    import ihds_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  image_format,
    input wire logic        dims_valid,
    input wire logic [31:0] image_width,
    input wire logic [31:0] image_height
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(image_format) &&
        $stable(dims_valid) && $stable(image_width) && $stable(image_height))
        else $error("result transaction changed while stalled");

    a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dims_valid |-> image_width != 32'd0 && image_height != 32'd0)
        else $error("dims_valid with a zero dimension");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !dims_valid |-> image_width == 32'd0 && image_height == 32'd0)
        else $error("dimensions reported without dims_valid");

    a_valid_format: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dims_valid |-> image_format != FMT_UNKNOWN)
        else $error("dims_valid on an unknown format");

endmodule

bind image_header_dimension_sniffer ihds_checker u_ihds_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (dims_chan.valid),
    .out_ready    (dims_chan.ready),
    .image_format (dims_chan.image_format),
    .dims_valid   (dims_chan.dims_valid),
    .image_width  (dims_chan.image_width),
    .image_height (dims_chan.image_height)
);

`default_nettype wire

### test/tb_image_header_dimension_sniffer.sv
`timescale 1ns / 1ps

module tb_image_header_dimension_sniffer;
    import ihds_pkg::*;

    // Fixed header words, most significant byte first
    localparam logic [63:0] PNG_MAGIC = 64'h8950_4E47_0D0A_1A0A;
    localparam logic [31:0] IHDR_WORD = 32'h4948_4452;

    // Hold-off of the result side while the byte side keeps offering
    localparam int HOLD_CYCLES   = 300;
    // Cycles without any transaction before the run is declared hung
    localparam int STALL_LIMIT   = 2000;
    // Least number of bytes sent in each random phase
    localparam int PHASE_BYTES   = 150;

    // True for the start-of-frame markers C0-C3, C5-C7, C9-CB, CD-CF
    function automatic logic frame_marker(input logic [7:0] m);
        return (m[7:4] == 4'hC) && (m[3:0] != 4'h4) && (m[3:0] != 4'h8) &&
               (m[3:0] != 4'hC);
    endfunction

    // Predicts the dimension record of each file and holds the records still owed
    class header_dims_tracker;
        fmt_t         fmt;
        logic         sig_bad;
        logic [4:0]   hdr_off;
        logic [31:0]  w_acc;
        logic [31:0]  h_acc;
        phase_t       walk_phase;
        logic         seg_is_sof;
        logic [15:0]  seg_remaining;
        logic [2:0]   sof_idx;
        logic         sof_seen;
        dims_result_t expected_dims[$];
        int           mismatches;
        int           files_done;
        int           dims_ok_count;
        int           fmt_count[4];

        function new();
            restart();
        endfunction

        function void restart();
            fmt           = FMT_UNKNOWN;
            sig_bad       = 1'b0;
            hdr_off       = 5'd0;
            w_acc         = 32'd0;
            h_acc         = 32'd0;
            walk_phase    = PH_SEEK;
            seg_is_sof    = 1'b0;
            seg_remaining = 16'd0;
            sof_idx       = 3'd0;
            sof_seen      = 1'b0;
        endfunction

        function int pending();
            return expected_dims.size();
        endfunction

        // One step of the JPEG marker walk
        function void advance_walk(input logic [7:0] b);
            case (walk_phase)
                PH_SEEK:
                begin
                    if (b == JPEG_PREFIX)
                        walk_phase = PH_RUN;
                end
                PH_RUN:
                begin
                    if (b != JPEG_PREFIX)
                    begin
                        if (b == JPEG_SOI || b == JPEG_EOI)
                            walk_phase = PH_SEEK;
                        else
                        begin
                            seg_is_sof = frame_marker(b);
                            walk_phase = PH_LEN_HI;
                        end
                    end
                end
                PH_LEN_HI:
                begin
                    seg_remaining = {b, 8'h00};
                    walk_phase    = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    seg_remaining[7:0] = b;
                    if (seg_remaining < 16'd2 || (seg_is_sof && seg_remaining < 16'd7))
                        walk_phase = PH_FAIL;
                    else
                    begin
                        seg_remaining = seg_remaining - 16'd2;
                        sof_idx       = 3'd0;
                        walk_phase    = (seg_remaining == 16'd0) ? PH_SEEK : PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (seg_is_sof)
                    begin
                        if (sof_idx == 3'd1 || sof_idx == 3'd2)
                            h_acc = {h_acc[23:0], b};
                        else if (sof_idx == 3'd3 || sof_idx == 3'd4)
                            w_acc = {w_acc[23:0], b};
                        if (sof_idx != 3'd7)
                            sof_idx = sof_idx + 3'd1;
                    end
                    seg_remaining = seg_remaining - 16'd1;
                    if (seg_remaining == 16'd0)
                    begin
                        if (seg_is_sof)
                        begin
                            sof_seen   = 1'b1;
                            walk_phase = PH_DONE;
                        end
                        else
                            walk_phase = PH_SEEK;
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        // Advance the header parse by one accepted byte; owe a record on the last one
        function void note_byte(input logic [7:0] b, input logic last);
            int           k;
            logic         ok;
            logic [31:0]  h;
            dims_result_t res;
            k = hdr_off;
            if (!sig_bad)
            begin
                if (k == 0)
                begin
                    if (b == PNG_FIRST)
                        fmt = FMT_PNG;
                    else if (b == BMP_FIRST)
                        fmt = FMT_BMP;
                    else if (b == JPEG_PREFIX)
                        fmt = FMT_JPEG;
                    else
                        sig_bad = 1'b1;
                end
                else if (fmt == FMT_PNG)
                begin
                    if (k < 8)
                    begin
                        if (b != PNG_MAGIC[8*(7-k) +: 8])
                            sig_bad = 1'b1;
                    end
                    else if (k >= 12 && k < 16)
                    begin
                        if (b != IHDR_WORD[8*(15-k) +: 8])
                            sig_bad = 1'b1;
                    end
                    else if (k >= 16 && k < 20)
                        w_acc = {w_acc[23:0], b};
                    else if (k >= 20 && k < 24)
                        h_acc = {h_acc[23:0], b};
                end
                else if (fmt == FMT_BMP)
                begin
                    if (k == 1)
                    begin
                        if (b != BMP_SECOND)
                            sig_bad = 1'b1;
                    end
                    else if (k >= 18 && k < 22)
                        w_acc = w_acc | ({24'd0, b} << (8 * (k - 18)));
                    else if (k >= 22 && k < 26)
                        h_acc = h_acc | ({24'd0, b} << (8 * (k - 22)));
                end
                else if (fmt == FMT_JPEG)
                begin
                    if (k == 1)
                    begin
                        if (b != JPEG_SOI)
                            sig_bad = 1'b1;
                    end
                    else
                        advance_walk(b);
                end
            end
            if (hdr_off != OFF_MAX)
                hdr_off = hdr_off + 5'd1;

            if (last)
            begin
                res.image_format = FMT_UNKNOWN;
                ok = 1'b0;
                h  = h_acc;
                if (!sig_bad)
                begin
                    if (fmt == FMT_PNG && k >= MIN_LAST_PNG)
                    begin
                        res.image_format = FMT_PNG;
                        ok = 1'b1;
                    end
                    else if (fmt == FMT_BMP && k >= MIN_LAST_BMP)
                    begin
                        res.image_format = FMT_BMP;
                        ok = 1'b1;
                        if (h[31])
                            h = ~h + 32'd1;
                    end
                    else if (fmt == FMT_JPEG && k >= MIN_LAST_JPEG)
                    begin
                        res.image_format = FMT_JPEG;
                        ok = sof_seen;
                    end
                end
                ok = ok && (w_acc != 32'd0) && (h != 32'd0);
                res.dims_valid   = ok;
                res.image_width  = ok ? w_acc : 32'd0;
                res.image_height = ok ? h : 32'd0;
                expected_dims.push_back(res);
                files_done++;
                fmt_count[int'(res.image_format)]++;
                if (ok)
                    dims_ok_count++;
                restart();
            end
        endfunction

        task report_mismatch(input string msg);
            mismatches++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        // Compare one record from the block with the oldest one owed
        task check_dims(input dims_result_t got);
            dims_result_t want;
            string        diffs;
            if (expected_dims.size() == 0)
                report_mismatch($sformatf("unexpected record fmt=%0d ok=%0b w=%0h h=%0h",
                                          got.image_format, got.dims_valid,
                                          got.image_width, got.image_height));
            else
            begin
                want  = expected_dims.pop_front();
                diffs = "";
                if (got.image_format !== want.image_format)
                    diffs = {diffs, $sformatf(" format %0d/%0d", got.image_format,
                                              want.image_format)};
                if (got.dims_valid !== want.dims_valid)
                    diffs = {diffs, $sformatf(" dims_valid %0b/%0b", got.dims_valid,
                                              want.dims_valid)};
                if (got.image_width !== want.image_width)
                    diffs = {diffs, $sformatf(" width %0h/%0h", got.image_width,
                                              want.image_width)};
                if (got.image_height !== want.image_height)
                    diffs = {diffs, $sformatf(" height %0h/%0h", got.image_height,
                                              want.image_height)};
                if (diffs != "")
                    report_mismatch({"record got/expected:", diffs});
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    ihds_byte_if byte_chan ();
    ihds_dims_if dims_chan ();

    image_header_dimension_sniffer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_chan (byte_chan),
        .dims_chan (dims_chan)
    );

    header_dims_tracker dims_log;

    // Bytes of the file being assembled before it goes out on byte_chan
    logic [7:0] file_bytes[$];
    int         bytes_sent;
    int         src_idle_pct;
    int         sink_idle_pct;
    int         phase_no;
    logic       hold_dims;
    int         quiet_cycles;

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // File assembly helpers: each one appends bytes to file_bytes
    // ---------------------------------------------------------------------

    // Append the low n bytes of v, most significant first
    task automatic push_octets(input logic [255:0] v, input int n);
        int k;
        for (k = n - 1; k >= 0; k--)
            file_bytes.push_back(v[8*k +: 8]);
    endtask

    task automatic push_random(input int n);
        repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic push_le32(input logic [31:0] v);
        int k;
        for (k = 0; k < 4; k++)
            file_bytes.push_back(v[8*k +: 8]);
    endtask

    // Favor the corners: zero, one, all ones, small, then anything
    function automatic logic [31:0] pick_dim32();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd1;
            3:       return 32'($urandom_range(1, 4096));
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_dim16();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // BMP height: top-down (negative) rows are common, and the most negative value
    function automatic logic [31:0] pick_bmp_height();
        logic [31:0] h;
        h = pick_dim32();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1, 2, 3: return ~h + 32'd1;
            default: return h;
        endcase
    endfunction

    task automatic build_png(input logic [31:0] w, input logic [31:0] h, input int tail);
        push_octets(PNG_MAGIC, 8);
        push_octets(32'd13, 4);
        push_octets(IHDR_WORD, 4);
        push_octets(w, 4);
        push_octets(h, 4);
        push_random(tail);
    endtask

    task automatic build_bmp(input logic [31:0] w, input logic [31:0] h, input int tail);
        file_bytes.push_back(BMP_FIRST);
        file_bytes.push_back(BMP_SECOND);
        push_random(16);
        push_le32(w);
        push_le32(h);
        push_random(tail);
    endtask

    // A marker byte that opens an ordinary segment (carries a length, not a frame)
    function automatic logic [7:0] pick_plain_marker();
        logic [7:0] m;
        case ($urandom_range(0, 3))
            0: m = 8'hE0;
            1: m = 8'hDB;
            2: m = 8'hC4;
            default:
            begin
                m = 8'($urandom_range(0, 255));
                while (m == JPEG_PREFIX || m == JPEG_SOI || m == JPEG_EOI || frame_marker(m))
                    m = 8'($urandom_range(0, 255));
            end
        endcase
        return m;
    endfunction

    // JPEG: SOI, a few ordinary segments, fill, stray markers, then mostly a frame header
    task automatic build_jpeg();
        int          nseg;
        int          r;
        int          seglen;
        logic [7:0]  m;
        logic [15:0] h;
        logic [15:0] w;
        push_octets(16'hFFD8, 2);
        nseg = $urandom_range(0, 3);
        repeat (nseg)
        begin
            // fill bytes in front of the marker prefix are skipped
            repeat ($urandom_range(0, 2))
            begin
                m = 8'($urandom_range(0, 254));
                file_bytes.push_back(m);
            end
            r = $urandom_range(0, 99);
            if (r < 10)
                push_octets({JPEG_PREFIX, (r < 5) ? JPEG_SOI : JPEG_EOI}, 2);
            else
            begin
                repeat ($urandom_range(1, 3)) file_bytes.push_back(JPEG_PREFIX);
                file_bytes.push_back(pick_plain_marker());
                if (r < 16)
                begin
                    // long segment cut off by the end of the file
                    file_bytes.push_back(8'($urandom_range(1, 255)));
                    push_random(1 + $urandom_range(0, 6));
                    return;
                end
                else if (r < 20)
                    push_octets({8'h00, 7'd0, 1'($urandom_range(0, 1))}, 2);
                else
                begin
                    seglen = $urandom_range(2, 10);
                    push_octets(16'(seglen), 2);
                    push_random(seglen - 2);
                end
            end
        end
        if ($urandom_range(0, 99) < 88)
        begin
            repeat ($urandom_range(1, 2)) file_bytes.push_back(JPEG_PREFIX);
            m = 8'($urandom_range(8'hC0, 8'hCF));
            while (!frame_marker(m))
                m = 8'($urandom_range(8'hC0, 8'hCF));
            file_bytes.push_back(m);
            seglen = ($urandom_range(0, 99) < 12) ? $urandom_range(2, 6) : $urandom_range(7, 14);
            push_octets(16'(seglen), 2);
            h = pick_dim16();
            w = pick_dim16();
            push_octets({8'd8, h, w}, 5);
            if (seglen > 7)
                push_random(seglen - 7);
        end
        // anything after the frame header is ignored
        push_random($urandom_range(0, 6));
    endtask

    // Files that match no signature, short ones may start with a real prefix
    task automatic build_noise();
        int         len;
        logic [7:0] first;
        len   = $urandom_range(1, 20);
        first = 8'($urandom_range(0, 255));
        if (len > 3)
        begin
            while (first == PNG_FIRST || first == BMP_FIRST || first == JPEG_PREFIX)
                first = 8'($urandom_range(0, 255));
        end
        file_bytes.push_back(first);
        push_random(len - 1);
    endtask

    // Truncate the file or flip bits somewhere in its header
    task automatic damage_file();
        int         cut;
        int         span;
        int         pos;
        logic [7:0] flip;
        if ($urandom_range(0, 1) == 0)
        begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut)
                file_bytes.delete(file_bytes.size() - 1);
        end
        else
        begin
            span = (file_bytes.size() < 26) ? file_bytes.size() : 26;
            pos  = $urandom_range(0, span - 1);
            flip = 8'($urandom_range(1, 255));
            file_bytes[pos] = file_bytes[pos] ^ flip;
        end
    endtask

    task automatic build_random_file();
        int r;
        r = $urandom_range(0, 99);
        if (r < 28)
            build_png(pick_dim32(), pick_dim32(), $urandom_range(0, 10));
        else if (r < 54)
            build_bmp(pick_dim32(), pick_bmp_height(), $urandom_range(0, 10));
        else if (r < 88)
            build_jpeg();
        else
            build_noise();
        if (r < 88 && $urandom_range(0, 99) < 18)
            damage_file();
    endtask

    // ---------------------------------------------------------------------
    // Byte side driver
    // ---------------------------------------------------------------------

    // Offer one byte; idle first at the configured rate, then hold until accepted
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            byte_chan.valid <= 1'b0;
            @(posedge clk);
        end
        byte_chan.valid     <= 1'b1;
        byte_chan.data_byte <= value;
        byte_chan.last_byte <= is_last;
        @(posedge clk);
        while (!byte_chan.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Send the assembled file with last_byte on its final byte, then drop it
    task automatic send_file();
        int k;
        for (k = 0; k < file_bytes.size(); k++)
            send_byte(file_bytes[k], k == file_bytes.size() - 1);
        file_bytes.delete();
    endtask

    // ---------------------------------------------------------------------
    // Monitor: note accepted bytes, check accepted records, drive ready,
    // and watch for a hang. Everything is sampled at the rising edge, so the
    // values seen are those the block saw at that same edge.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        dims_result_t got;
        logic         took_byte;
        logic         took_dims;
        took_byte = byte_chan.valid && byte_chan.ready;
        took_dims = dims_chan.valid && dims_chan.ready;
        if (rst_n)
        begin
            if (took_byte)
                dims_log.note_byte(byte_chan.data_byte, byte_chan.last_byte);
            if (took_dims)
            begin
                got.image_format = fmt_t'(dims_chan.image_format);
                got.dims_valid   = dims_chan.dims_valid;
                got.image_width  = dims_chan.image_width;
                got.image_height = dims_chan.image_height;
                dims_log.check_dims(got);
            end
            if (took_byte || took_dims)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d records owed",
                         quiet_cycles, dims_log.pending());
                $display("CHECK FAILED");
                $finish;
            end
        end
        // Stall the result side at random, and hard during the hold-off
        dims_chan.ready <= !hold_dims && ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Hold off the result side for a long stretch in the last phase, while the
    // byte side keeps offering: the output register stays full and the next
    // last byte backs up into byte_chan.
    initial
    begin
        wait (phase_no == 3);
        @(posedge clk);
        hold_dims <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_dims <= 1'b0;
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial
    begin
        int phase_start;
        byte_chan.valid     = 1'b0;
        byte_chan.data_byte = 8'd0;
        byte_chan.last_byte = 1'b0;
        dims_chan.ready     = 1'b0;
        rst_n               = 1'b0;
        hold_dims           = 1'b0;
        quiet_cycles        = 0;
        bytes_sent          = 0;
        phase_no            = 0;
        src_idle_pct        = 6;
        sink_idle_pct       = 57;
        dims_log            = new();

        // Hold reset, then release it once
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed files, under the first idling mix.
        // PNG of exactly 24 bytes, then the largest dimensions with trailing bytes
        build_png(32'd1, 32'd1, 0);
        send_file();
        build_png(32'hFFFF_FFFF, 32'hFFFF_FFFF, 9);
        send_file();
        // PNG one byte short, PNG with a broken IHDR tag, PNG of zero width
        build_png(32'd5, 32'd7, 0);
        file_bytes.delete(file_bytes.size() - 1);
        send_file();
        build_png(32'd5, 32'd7, 2);
        file_bytes[13] = file_bytes[13] ^ 8'h20;
        send_file();
        build_png(32'd0, 32'd5, 0);
        send_file();
        // BMP top-down, BMP with the most negative height, BMP one byte short
        build_bmp(32'd640, 32'hFFFF_FE20, 0);
        send_file();
        build_bmp(32'd1, 32'h8000_0000, 3);
        send_file();
        build_bmp(32'd100, 32'd100, 0);
        file_bytes.delete(file_bytes.size() - 1);
        send_file();
        // Smallest JPEG frame header
        push_octets(88'hFFD8_FFC0_0007_0800_1000_20, 11);
        send_file();
        // JPEG with fill, an FF run, stray SOI/EOI, an empty segment, a segment
        // longer than 255 bytes, then a frame header and a second one to ignore
        push_octets(32'hFFD8_0012, 4);
        push_octets(40'hFFFF_D8FF_D9, 5);
        push_octets(32'hFFE0_0002, 4);
        push_octets(32'hFFFE_0102, 4);
        push_random(256);
        push_octets(88'hFFFF_C200_0808_01E0_0280_03, 11);
        push_octets(32'hFFC0_0007, 4);
        push_random(5);
        send_file();
        // Segment length below 2, frame length below 7, frame cut off by the end
        push_octets(120'hFFD8_FFDB_0001_FFC0_0007_0800_1000_10, 15);
        send_file();
        push_octets(96'hFFD8_FFC1_0006_0800_1000_1010, 12);
        send_file();
        push_octets(88'hFFD8_FFC0_0011_0800_1000_10, 11);
        send_file();
        // JPEG below its minimum length, then at it without a frame
        push_octets(24'hFFD8_00, 3);
        send_file();
        push_octets(32'hFFD8_FFD9, 4);
        send_file();
        // One-byte files: each prefix alone and an unknown byte
        push_octets(PNG_FIRST, 1);
        send_file();
        push_octets(BMP_FIRST, 1);
        send_file();
        push_octets(JPEG_PREFIX, 1);
        send_file();
        push_octets(8'h00, 1);
        send_file();

        // Random phases: sender lean / receiver busy, the reverse, then no idling
        // with the long hold-off on the result side.
        for (phase_no = 1; phase_no <= 3; phase_no++)
        begin
            src_idle_pct  = (phase_no == 1) ? 6 : (phase_no == 2) ? 57 : 0;
            sink_idle_pct = (phase_no == 1) ? 57 : (phase_no == 2) ? 6 : 0;
            phase_start   = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                build_random_file();
                send_file();
            end
        end
        byte_chan.valid <= 1'b0;

        // Drain: wait for every owed record, then keep watching for strays
        while (dims_log.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sniffed %0d files in %0d bytes: %0d png, %0d bmp, %0d jpeg, %0d unknown.",
                 dims_log.files_done, bytes_sent, dims_log.fmt_count[FMT_PNG],
                 dims_log.fmt_count[FMT_BMP], dims_log.fmt_count[FMT_JPEG],
                 dims_log.fmt_count[FMT_UNKNOWN]);
        $display("%0d files gave valid dimensions; %0d record mismatches.",
                 dims_log.dims_ok_count, dims_log.mismatches);
        if (dims_log.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
